// ===== design/sensor_packet_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef SENSOR_PACKET_DEFRAMER_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SPD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SPD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spd_pkg.sv =====
`default_nettype none

package spd_pkg;

    // Frame geometry.
    localparam int PAYLOAD_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_W     = 64;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int STORE_IDX_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [CNT_W-1:0] PAYLOAD_LAST = CNT_W'(PAYLOAD_BYTES);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ID_MASK_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN = 3'd3;

    localparam logic [BYTE_W-1:0]    HEADER_RST   = 8'd85;
    localparam logic [BYTE_W-1:0]    ID_BASE_RST  = 8'd80;
    localparam logic [ID_MASK_W-1:0] ID_MASK_RST  = 16'd2047;
    localparam logic                 CHECK_EN_RST = 1'b0;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_ID     = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // Configuration settings seen by the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]    header_value;
        logic [BYTE_W-1:0]    id_base;
        logic [ID_MASK_W-1:0] id_enable_mask;
        logic                 check_enable;
    } cfg_t;

    // One completed frame.
    typedef struct packed {
        logic [BYTE_W-1:0]    frame_id;
        logic [PAYLOAD_W-1:0] frame_payload;
        logic [BYTE_W-1:0]    frame_checksum;
        logic                 checksum_match;
    } frame_t;

endpackage

`default_nettype wire

// ===== design/spd_cfg_regs.sv =====
`default_nettype none

module spd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output spd_pkg::cfg_t                         cfg
);

    spd_pkg::cfg_t cfg_reg;

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value   <= spd_pkg::HEADER_RST;
            cfg_reg.id_base        <= spd_pkg::ID_BASE_RST;
            cfg_reg.id_enable_mask <= spd_pkg::ID_MASK_RST;
            cfg_reg.check_enable   <= spd_pkg::CHECK_EN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spd_pkg::REG_HEADER:
                    cfg_reg.header_value <= cfg_data[spd_pkg::BYTE_W-1:0];
                spd_pkg::REG_ID_BASE:
                    cfg_reg.id_base <= cfg_data[spd_pkg::BYTE_W-1:0];
                spd_pkg::REG_ID_MASK:
                    cfg_reg.id_enable_mask <= cfg_data[spd_pkg::ID_MASK_W-1:0];
                spd_pkg::REG_CHECK_EN:
                    cfg_reg.check_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/spd_in_reg.sv =====
`default_nettype none

module spd_in_reg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [spd_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                          advance,
    output      logic                          byte_valid,
    output      logic [spd_pkg::BYTE_W-1:0]    byte_data
);

    logic                       valid_reg;
    logic [spd_pkg::BYTE_W-1:0] data_reg;

    // The held beat blocks the channel only while the parser cannot move.
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // Byte holding register, loaded with each accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/spd_parser.sv =====
`default_nettype none

module spd_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [spd_pkg::BYTE_W-1:0]    byte_data,
    input  wire spd_pkg::cfg_t                 cfg,
    output      logic                          res_valid,
    output spd_pkg::frame_t                    res
);

    spd_pkg::phase_t                 phase_reg;
    spd_pkg::phase_t                 phase_next;
    logic [spd_pkg::CNT_W-1:0]       count_reg;
    logic [spd_pkg::CNT_W-1:0]       count_next;
    logic [spd_pkg::BYTE_W-1:0]      id_reg;
    logic [spd_pkg::BYTE_W-1:0]      id_next;
    logic [spd_pkg::BYTE_W-1:0]      sum_reg;
    logic [spd_pkg::BYTE_W-1:0]      sum_next;
    logic [spd_pkg::BYTE_W-1:0]      store_reg [spd_pkg::PAYLOAD_BYTES];
    logic                            store_we;
    logic                            emit;
    logic                            match;
    logic [spd_pkg::BYTE_W-1:0]      id_offset;
    logic                            id_known;
    logic [spd_pkg::PAYLOAD_W-1:0]   payload;

    // Identifier window: offset from the base, wrapping modulo 256.
    assign id_offset = byte_data - cfg.id_base;
    assign id_known  = (id_offset[spd_pkg::BYTE_W-1:4] == '0)
                       && cfg.id_enable_mask[id_offset[3:0]];
    assign match     = (sum_reg == byte_data);

    // Gather the stored payload, first byte in the low bits.
    always_comb
    begin
        payload = '0;
        for (int i = 0; i < spd_pkg::PAYLOAD_BYTES; i++)
        begin
            payload[spd_pkg::BYTE_W*i +: spd_pkg::BYTE_W] = store_reg[i];
        end
    end

    // Next-state decode for one byte.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        id_next    = id_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        emit       = 1'b0;
        case (phase_reg)
            spd_pkg::PH_ID:
            begin
                if (id_known)
                begin
                    id_next    = byte_data;
                    count_next = '0;
                    sum_next   = sum_reg + byte_data;
                    phase_next = spd_pkg::PH_DATA;
                end
                else
                begin
                    phase_next = spd_pkg::PH_SEARCH;
                end
            end
            spd_pkg::PH_DATA:
            begin
                if (count_reg == spd_pkg::PAYLOAD_LAST)
                begin
                    // Checksum byte closes the frame.
                    phase_next = spd_pkg::PH_SEARCH;
                    emit       = !cfg.check_enable || match;
                end
                else
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + spd_pkg::CNT_W'(1);
                    sum_next   = sum_reg + byte_data;
                end
            end
            default:
            begin
                // Searching for the header byte.
                if (byte_data == cfg.header_value)
                begin
                    sum_next   = byte_data;
                    phase_next = spd_pkg::PH_ID;
                end
                else
                begin
                    phase_next = spd_pkg::PH_SEARCH;
                end
            end
        endcase
    end

    // Control and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= spd_pkg::PH_SEARCH;
            count_reg <= '0;
            id_reg    <= '0;
            sum_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload store, written one byte per data beat.
    always_ff @(posedge clk)
    begin
        if (fire && store_we)
        begin
            store_reg[count_reg[spd_pkg::STORE_IDX_W-1:0]] <= byte_data;
        end
    end

    assign res_valid          = fire && emit;
    assign res.frame_id       = id_reg;
    assign res.frame_payload  = payload;
    assign res.frame_checksum = byte_data;
    assign res.checksum_match = match;

endmodule

`default_nettype wire

// ===== design/spd_out_reg.sv =====
`default_nettype none

module spd_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    input  wire spd_pkg::frame_t res,
    output      logic          advance,
    output      logic          out_valid,
    input  wire logic          out_stall,
    output spd_pkg::frame_t    frame
);

    logic            valid_reg;
    spd_pkg::frame_t frame_reg;

    // The register can take a new frame when empty or being drained.
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    // Frame contents hold while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            frame_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign frame     = frame_reg;

endmodule

`default_nettype wire

// ===== design/sensor_packet_deframer.sv =====
// Sum-checksum packet deframer.
// Input channel: one received byte per beat on rx_byte, handshake in_valid and
// in_stall. Output channel: one completed frame per beat on frame_id,
// frame_payload, frame_checksum and checksum_match, handshake out_valid and
// out_stall. A beat moves on a rising edge with valid high and stall low.
// A frame is a header byte, a registered identifier, eight payload bytes and a
// checksum byte; frames failing the sum are dropped when check_enable is set.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// (0 header_value, 1 id_base, 2 id_enable_mask, 3 check_enable); the user
// must write them only while idle, which the block itself does not enforce.
// The checksum byte moves from the input register through the parser stage
// into the frame register, which drives out_valid; throughput is one byte per
// cycle while the frame register is not stalled.
// When the receiver stalls a waiting frame, the parser holds; in_stall is high
// whenever the input register holds a byte that cannot move on, so at most one
// more beat is taken after the stall begins.
// Reset clears the parser to header search, empties both registers and
// restores the configuration defaults; no clearing pass is needed.
`default_nettype none

`include "sensor_packet_deframer_defines.svh"

module sensor_packet_deframer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic [spd_pkg::BYTE_W-1:0]       rx_byte,
    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic [spd_pkg::BYTE_W-1:0]       frame_id,
    output      logic [spd_pkg::PAYLOAD_W-1:0]    frame_payload,
    output      logic [spd_pkg::BYTE_W-1:0]       frame_checksum,
    output      logic                             checksum_match,
    input  wire logic                             cfg_we,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    spd_pkg::cfg_t              cfg;
    spd_pkg::frame_t            res;
    spd_pkg::frame_t            frame;
    logic                       res_valid;
    logic                       advance;
    logic                       byte_valid;
    logic [spd_pkg::BYTE_W-1:0] byte_data;
    logic                       fire;

    spd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // A held byte is parsed whenever the frame register can move.
    assign fire = byte_valid && advance;

    spd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_data (byte_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    spd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .frame     (frame)
    );

    assign frame_id       = frame.frame_id;
    assign frame_payload  = frame.frame_payload;
    assign frame_checksum = frame.frame_checksum;
    assign checksum_match = frame.checksum_match;

    // A parsed frame always lands in the frame register.
    `SPD_ASSERT_NXT(a_frame_lands, fire && res_valid, out_valid, "parsed frame was not registered")

    // The input side only stalls behind a stalled frame.
    `SPD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // A new frame beat needs a parse in the cycle before.
    `SPD_ASSERT_IMP(a_frame_source, $rose(out_valid), $past(fire), "frame appeared without a parsed byte")

endmodule

`default_nettype wire
